### design/next_fit_free_list_allocator_unit_assert.svh
// Assertion macros for the free-list allocator
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NFFL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define NFFL_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define NFFL_ASSERT(lbl, clk, rst, prop, msg)
`define NFFL_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)
`endif
`endif

### design/nffl_pkg.sv
package nffl_pkg;
   localparam int HEAP_UNITS = 4096;
   localparam int UNIT_BYTES = 16;
   localparam int ADDR_W = $clog2(HEAP_UNITS);
   localparam int EXT_W = ADDR_W + 1;
   localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
   localparam int ALLOC_STEP_LIMIT = 3 * HEAP_UNITS + 4;
   localparam int FREE_STEP_LIMIT = HEAP_UNITS + 2;
   localparam int ASTEP_W = $clog2(ALLOC_STEP_LIMIT + 2);
   localparam int RSTEP_W = $clog2(FREE_STEP_LIMIT + 2);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;
   localparam logic CSR_MIN_GROW = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] next;
      logic [ADDR_W-1:0] size;
   } hdr_type;

   typedef struct packed {
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      hdr_type wr_data;
   } mem_req_type;
endpackage

### design/nffl_hdr_ram.sv
module nffl_hdr_ram
   import nffl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  mem_req_type mem_req,
   output hdr_type rd_data
);
   hdr_type mem [HEAP_UNITS];
   hdr_type rd_ff;
   logic sent_ok_ff;
   logic rd_zero_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_ff <= mem[mem_req.rd_addr];
         rd_zero_ff <= (mem_req.rd_addr == '0) && !sent_ok_ff;
      end
   end

   // sentinel reads as self-linked, size zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ok_ff <= 1'b0;
      end else if (mem_req.wr_en && mem_req.wr_addr == '0) begin
         sent_ok_ff <= 1'b1;
      end
   end

   assign rd_data = rd_zero_ff ? '0 : rd_ff;
endmodule

### design/nffl_ctrl.sv
module nffl_ctrl
   import nffl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_op,
   input  logic [15:0] req_request_bytes,
   input  logic [12:0] req_free_address,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [12:0] rsp_data_address,
   output logic rsp_status,
   input  logic [11:0] min_grow,
   input  logic [11:0] heap_limit,
   output mem_req_type mem_req,
   input  hdr_type rd_data
);
`include "next_fit_free_list_allocator_unit_assert.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_A_ROV = 4'd1;
   localparam logic [3:0] S_A_ROVD = 4'd2;
   localparam logic [3:0] S_A_CHK = 4'd3;
   localparam logic [3:0] S_A_SPLIT = 4'd4;
   localparam logic [3:0] S_G_CHK = 4'd5;
   localparam logic [3:0] S_F_SZ = 4'd6;
   localparam logic [3:0] S_R_ROV = 4'd7;
   localparam logic [3:0] S_R_CHK = 4'd8;
   localparam logic [3:0] S_R_UP = 4'd9;
   localparam logic [3:0] S_R_WB = 4'd10;
   localparam logic [3:0] S_R_WC = 4'd11;
   localparam logic [3:0] S_R_END = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;

   logic [3:0] state_ff, state_in;
   logic grow_ff, grow_in;
   logic [EXT_W-1:0] units_ff, units_in;
   logic [ADDR_W-1:0] prev_ff, prev_in, psize_ff, psize_in;
   logic [ADDR_W-1:0] cur_ff, cur_in, csize_ff, csize_in;
   logic [ADDR_W-1:0] b_ff, b_in, bsize_ff, bsize_in;
   hdr_type bnew_ff, bnew_in;
   logic [EXT_W-1:0] split_ff, split_in;
   logic [ASTEP_W-1:0] astep_ff, astep_in;
   logic [RSTEP_W-1:0] rstep_ff, rstep_in;
   logic [EXT_W-1:0] heap_top_ff, heap_top_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic [EXT_W-1:0] res_addr_ff, res_addr_in;
   logic res_stat_ff, res_stat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [EXT_W-1:0] out_addr_ff, out_addr_in;
   logic out_stat_ff, out_stat_in;

   // shared datapath terms
   logic [EXT_W-1:0] csize_ext, grow_n;
   logic [EXT_W:0] grow_end;
   logic [16:0] bytes_rnd;
   logic rel_found;

   assign bytes_rnd = {1'b0, req_request_bytes} + 17'(UNIT_BYTES - 1);
   assign csize_ext = {1'b0, rd_data.size};
   assign grow_n = (units_ff < {1'b0, min_grow}) ? {1'b0, min_grow} : units_ff;
   assign grow_end = {1'b0, heap_top_ff} + {1'b0, grow_n};
   assign rel_found = (b_ff > cur_ff && b_ff < rd_data.next) ||
                      (cur_ff >= rd_data.next && (b_ff > cur_ff || b_ff < rd_data.next));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_address = out_addr_ff;
   assign rsp_status = out_stat_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      grow_in = grow_ff;
      units_in = units_ff;
      prev_in = prev_ff;
      psize_in = psize_ff;
      cur_in = cur_ff;
      csize_in = csize_ff;
      b_in = b_ff;
      bsize_in = bsize_ff;
      bnew_in = bnew_ff;
      split_in = split_ff;
      astep_in = astep_ff;
      rstep_in = rstep_ff;
      heap_top_in = heap_top_ff;
      rover_in = rover_ff;
      res_addr_in = res_addr_ff;
      res_stat_in = res_stat_ff;
      mem_req = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_addr_in = '0;
               res_stat_in = 1'b0;
               astep_in = '0;
               units_in = EXT_W'(bytes_rnd >> UNIT_SHIFT) + EXT_W'(1);
               if (req_op == OP_ALLOC) begin
                  state_in = S_A_ROV;
               end else if (req_free_address >= 13'd2 &&
                            (req_free_address - 13'd1) < heap_top_ff) begin
                  b_in = ADDR_W'(req_free_address - 13'd1);
                  grow_in = 1'b0;
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr = ADDR_W'(req_free_address - 13'd1);
                  state_in = S_F_SZ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_A_ROV: begin
            mem_req.rd_en = 1'b1;
            mem_req.rd_addr = rover_ff;
            state_in = S_A_ROVD;
         end
         S_A_ROVD: begin
            prev_in = rover_ff;
            psize_in = rd_data.size;
            cur_in = rd_data.next;
            mem_req.rd_en = 1'b1;
            mem_req.rd_addr = rd_data.next;
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (csize_ext == units_ff) begin
               // exact fit: unlink
               mem_req.wr_en = 1'b1;
               mem_req.wr_addr = prev_ff;
               mem_req.wr_data = '{next: rd_data.next, size: psize_ff};
               rover_in = prev_ff;
               res_addr_in = {1'b0, cur_ff} + EXT_W'(1);
               state_in = S_DONE;
            end else if (csize_ext > units_ff) begin
               // split off the tail
               mem_req.wr_en = 1'b1;
               mem_req.wr_addr = cur_ff;
               mem_req.wr_data = '{next: rd_data.next,
                                   size: rd_data.size - units_ff[ADDR_W-1:0]};
               split_in = {1'b0, cur_ff} + (csize_ext - units_ff);
               rover_in = prev_ff;
               state_in = S_A_SPLIT;
            end else if (cur_ff == rover_ff) begin
               state_in = S_G_CHK;
            end else if (astep_ff + ASTEP_W'(1) > ASTEP_W'(ALLOC_STEP_LIMIT)) begin
               res_stat_in = 1'b1;
               state_in = S_DONE;
            end else begin
               astep_in = astep_ff + ASTEP_W'(1);
               prev_in = cur_ff;
               psize_in = rd_data.size;
               cur_in = rd_data.next;
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = rd_data.next;
            end
         end
         S_A_SPLIT: begin
            if (split_ff < EXT_W'(HEAP_UNITS)) begin
               mem_req.wr_en = 1'b1;
               mem_req.wr_addr = split_ff[ADDR_W-1:0];
               mem_req.wr_data = '{next: '0, size: units_ff[ADDR_W-1:0]};
            end
            res_addr_in = split_ff + EXT_W'(1);
            state_in = S_DONE;
         end
         S_G_CHK: begin
            if (grow_end > {2'b0, heap_limit} || grow_end > (EXT_W+1)'(HEAP_UNITS)) begin
               res_stat_in = 1'b1;
               state_in = S_DONE;
            end else begin
               b_in = heap_top_ff[ADDR_W-1:0];
               bsize_in = grow_n[ADDR_W-1:0];
               heap_top_in = grow_end[EXT_W-1:0];
               grow_in = 1'b1;
               state_in = S_R_ROV;
            end
         end
         S_F_SZ: begin
            bsize_in = rd_data.size;
            state_in = S_R_ROV;
         end
         S_R_ROV: begin
            cur_in = rover_ff;
            rstep_in = '0;
            mem_req.rd_en = 1'b1;
            mem_req.rd_addr = rover_ff;
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            if (rel_found) begin
               csize_in = rd_data.size;
               if ({1'b0, b_ff} + {1'b0, bsize_ff} == {1'b0, rd_data.next}) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr = rd_data.next;
                  state_in = S_R_UP;
               end else begin
                  bnew_in = '{next: rd_data.next, size: bsize_ff};
                  state_in = S_R_WB;
               end
            end else if (rstep_ff + RSTEP_W'(1) > RSTEP_W'(FREE_STEP_LIMIT)) begin
               state_in = S_R_END;
            end else begin
               rstep_in = rstep_ff + RSTEP_W'(1);
               cur_in = rd_data.next;
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = rd_data.next;
            end
         end
         S_R_UP: begin
            bnew_in = '{next: rd_data.next, size: bsize_ff + rd_data.size};
            state_in = S_R_WB;
         end
         S_R_WB: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = b_ff;
            mem_req.wr_data = bnew_ff;
            state_in = S_R_WC;
         end
         S_R_WC: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = cur_ff;
            if ({1'b0, cur_ff} + {1'b0, csize_ff} == {1'b0, b_ff}) begin
               mem_req.wr_data = '{next: bnew_ff.next, size: csize_ff + bnew_ff.size};
            end else begin
               mem_req.wr_data = '{next: b_ff, size: csize_ff};
            end
            rover_in = cur_ff;
            state_in = S_R_END;
         end
         S_R_END: begin
            if (!grow_ff) begin
               state_in = S_DONE;
            end else if (astep_ff + ASTEP_W'(1) > ASTEP_W'(ALLOC_STEP_LIMIT)) begin
               res_stat_in = 1'b1;
               state_in = S_DONE;
            end else begin
               astep_in = astep_ff + ASTEP_W'(1);
               state_in = S_A_ROV;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_addr_in = out_addr_ff;
      out_stat_in = out_stat_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         out_addr_in = res_addr_ff;
         out_stat_in = res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         heap_top_ff <= EXT_W'(1);
         rover_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         heap_top_ff <= heap_top_in;
         rover_ff <= rover_in;
      end
   end

   always_ff @(posedge clock) begin
      grow_ff <= grow_in;
      units_ff <= units_in;
      prev_ff <= prev_in;
      psize_ff <= psize_in;
      cur_ff <= cur_in;
      csize_ff <= csize_in;
      b_ff <= b_in;
      bsize_ff <= bsize_in;
      bnew_ff <= bnew_in;
      split_ff <= split_in;
      astep_ff <= astep_in;
      rstep_ff <= rstep_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      out_addr_ff <= out_addr_in;
      out_stat_ff <= out_stat_in;
   end

   // checks
   `NFFL_ASSERT(a_top_range, clock, reset, heap_top_ff <= EXT_W'(HEAP_UNITS), "heap top overflow")
   `NFFL_ASSERT(a_one_port, clock, reset, !(mem_req.rd_en && mem_req.wr_en), "read and write together")
   `NFFL_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "took two items")
   `NFFL_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_address) && $stable(rsp_status), "result dropped")
endmodule

### design/next_fit_free_list_allocator_unit.sv
// Next-fit free-list heap allocator.
// req channel: op 0 allocates request_bytes, op 1 frees free_address (data
// unit, header plus one). One item is worked at a time; req_ready is high
// only while the sequencer is idle.
// rsp channel: one result per item, data_address (0 on failure and for
// frees) and status (1 when the heap cannot grow far enough or the walk
// step limit is hit). The sequencer makes at most one header read or
// write per cycle on a single-port header memory. An allocate walks the
// list from the rover, one block at a time; a growth adds a release walk;
// a free does one release walk.
// csr channel: index 0 min_grow_units, index 1 heap_limit_units; always
// ready. It is to be written only while idle; the block does not enforce it.
// Reset: rover at the sentinel, heap top at unit 1, registers to 1024 and
// 4095. The sentinel header reads self-linked, size zero until written.
// A stalled receiver holds the result register; one further item can be
// accepted and worked, and it waits for the register to drain.
module next_fit_free_list_allocator_unit
   import nffl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_op,
   input  logic [15:0] req_request_bytes,
   input  logic [12:0] req_free_address,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [12:0] rsp_data_address,
   output logic rsp_status,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [11:0] csr_data
);
   logic [11:0] min_grow_ff, heap_limit_ff;
   mem_req_type mem_req;
   hdr_type rd_data;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_grow_ff <= 12'd1024;
         heap_limit_ff <= 12'd4095;
      end else if (csr_valid) begin
         if (csr_index == CSR_MIN_GROW) begin
            min_grow_ff <= csr_data;
         end
         if (csr_index == CSR_HEAP_LIMIT) begin
            heap_limit_ff <= csr_data;
         end
      end
   end

   nffl_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_request_bytes(req_request_bytes),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data_address(rsp_data_address),
      .rsp_status(rsp_status),
      .min_grow(min_grow_ff),
      .heap_limit(heap_limit_ff),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );

   nffl_hdr_ram u_ram (
      .clock(clock),
      .reset(reset),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );
endmodule

### dv/next_fit_free_list_allocator_unit_tb.sv
`timescale 1ns / 100ps

import nffl_pkg::*;

typedef struct {
   logic [12:0] data_address;
   logic        status;
} alloc_result_type;

// Heap model plus the queue of results still owed by the block
class heap_scoreboard;
   int unsigned link_of [HEAP_UNITS];
   int unsigned size_of [HEAP_UNITS];
   int unsigned rover;
   int unsigned top;
   int unsigned min_grow;
   int unsigned limit;
   alloc_result_type owed[$];

   function new();
      foreach (link_of[i]) begin
         link_of[i] = 0;
         size_of[i] = 0;
      end
      rover = 0;
      top = 1;
      min_grow = 1024;
      limit = 4095;
   endfunction

   function void write_reg(logic idx, logic [11:0] val);
      if (idx == CSR_MIN_GROW) min_grow = val;
      else limit = val;
   endfunction

   function int unsigned nxt(int unsigned i);
      return (i < HEAP_UNITS) ? link_of[i] : 0;
   endfunction

   function int unsigned siz(int unsigned i);
      return (i < HEAP_UNITS) ? size_of[i] : 0;
   endfunction

   function void set_nxt(int unsigned i, int unsigned v);
      if (i < HEAP_UNITS) link_of[i] = v;
   endfunction

   function void set_siz(int unsigned i, int unsigned v);
      if (i < HEAP_UNITS) size_of[i] = v;
   endfunction

   // insert block at header b, merging with free neighbors
   function void release_block(int unsigned b);
      int unsigned cur, n, steps, up;
      cur = rover;
      steps = 0;
      forever begin
         n = nxt(cur);
         if (b > cur && b < n) break;
         if (cur >= n && (b > cur || b < n)) break;
         steps++;
         if (steps > HEAP_UNITS + 2) return;
         cur = n;
      end
      if (b + siz(b) == nxt(cur)) begin
         up = nxt(cur);
         set_siz(b, siz(b) + siz(up));
         set_nxt(b, nxt(up));
      end else begin
         set_nxt(b, nxt(cur));
      end
      if (cur + siz(cur) == b) begin
         set_siz(cur, siz(cur) + siz(b));
         set_nxt(cur, nxt(b));
      end else begin
         set_nxt(cur, b);
      end
      rover = cur;
   endfunction

   function bit grow(int unsigned units);
      int unsigned n, last;
      n = (units < min_grow) ? min_grow : units;
      last = top + n;
      if (last > limit || last > HEAP_UNITS) return 0;
      set_siz(top, n);
      release_block(top);
      top = last;
      return 1;
   endfunction

   // next-fit search; returns data unit or 0 on failure
   function int unsigned allocate(int unsigned bytes);
      int unsigned units, prev, cur, steps;
      units = (bytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      prev = rover;
      cur = nxt(prev);
      steps = 0;
      forever begin
         if (siz(cur) >= units) begin
            if (siz(cur) == units) begin
               set_nxt(prev, nxt(cur));
            end else begin
               set_siz(cur, siz(cur) - units);
               cur += siz(cur);
               set_siz(cur, units);
            end
            rover = prev;
            return cur + 1;
         end
         if (cur == rover) begin
            if (!grow(units)) return 0;
            cur = rover;
         end
         steps++;
         if (steps > 3 * HEAP_UNITS + 4) return 0;
         prev = cur;
         cur = nxt(cur);
      end
   endfunction

   // accepted item: update the heap, queue the owed result
   function logic [12:0] note_item(logic op, logic [15:0] bytes, logic [12:0] faddr);
      alloc_result_type r;
      int unsigned a;
      r.data_address = 0;
      r.status = 0;
      if (op == OP_ALLOC) begin
         a = allocate(bytes);
         if (a != 0) r.data_address = a[12:0];
         else r.status = 1;
      end else if (faddr >= 2 && faddr - 1 < top) begin
         release_block(faddr - 1);
      end
      owed.push_back(r);
      return r.data_address;
   endfunction

   // returns an empty string when the result matches
   function string check_result(logic [12:0] addr, logic status);
      alloc_result_type e;
      if (owed.size() == 0) return $sformatf("unexpected result addr %0d", addr);
      e = owed.pop_front();
      if (addr !== e.data_address || status !== e.status)
         return $sformatf("addr %0d status %0d, want addr %0d status %0d",
                          addr, status, e.data_address, e.status);
      return "";
   endfunction
endclass

module next_fit_free_list_allocator_unit_tb;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_op = OP_ALLOC;
   logic [15:0] req_request_bytes = 0;
   logic [12:0] req_free_address = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [12:0] rsp_data_address;
   logic        rsp_status;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = CSR_MIN_GROW;
   logic [11:0] csr_data = 0;

   heap_scoreboard sb = new();
   logic [12:0] live[$];
   int errors = 0;
   int cycles = 0;
   int hold_request = 0;
   int n_alloc_ok = 0, n_alloc_fail = 0, n_free = 0;

   next_fit_free_list_allocator_unit u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0d: %s", cycles, msg);
      errors++;
   endtask

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("next_fit_free_list_allocator_unit regression: fail");
         $finish;
      end
   end

   // result side: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      int stall;
      string msg;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            msg = sb.check_result(rsp_data_address, rsp_status);
            if (msg != "") report_mismatch(msg);
         end
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1;
         end else if ($urandom_range(99) < 25) begin
            rsp_ready <= 0;
            stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            repeat (stall) @(posedge clock);
            rsp_ready <= 1;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic write_reg(logic idx, logic [11:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_item(logic op, logic [15:0] bytes, logic [12:0] faddr, bit no_gap = 0);
      logic [12:0] a;
      int gap;
      req_valid <= 1;
      req_op <= op;
      req_request_bytes <= bytes;
      req_free_address <= faddr;
      do @(posedge clock); while (!req_ready);
      a = sb.note_item(op, bytes, faddr);
      if (op == OP_ALLOC) begin
         if (a != 0) begin
            live.push_back(a);
            n_alloc_ok++;
         end else begin
            n_alloc_fail++;
         end
      end else begin
         n_free++;
      end
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic free_live(int idx);
      logic [12:0] a;
      a = live[idx];
      live.delete(idx);
      send_item(OP_FREE, 16'($urandom), a);
   endtask

   // let the block go idle before touching registers
   task automatic drain();
      req_valid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_items(int count, int small_max);
      int r;
      logic [15:0] bytes;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 4) begin
            // out-of-heap frees are dropped by the block
            send_item(OP_FREE, 16'($urandom),
                      ($urandom_range(1)) ? 13'($urandom_range(1)) : 13'($urandom_range(8191, 4097)));
         end else if (live.size() > 0 && r < 48) begin
            free_live($urandom_range(live.size() - 1));
         end else begin
            if ($urandom_range(19) == 0) bytes = 16'($urandom);
            else bytes = 16'($urandom_range(small_max));
            send_item(OP_ALLOC, bytes, 13'($urandom));
         end
      end
   endtask

   initial begin
      logic [12:0] a0, a1, a2;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: size edges, failed request, ignored frees, merges, exact fit
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_ALLOC, 1, 0);
      send_item(OP_ALLOC, 16, 0);
      send_item(OP_ALLOC, 17, 0);
      send_item(OP_ALLOC, 16'hFFFF, 13'h1FFF);
      send_item(OP_FREE, 0, 0);
      send_item(OP_FREE, 0, 1);
      send_item(OP_FREE, 16'hFFFF, 13'h1FFF);
      send_item(OP_FREE, 0, 13'd4096);
      a0 = live[1];
      a1 = live[2];
      a2 = live[3];
      live = live[0:0];
      send_item(OP_FREE, 0, a0);
      send_item(OP_FREE, 0, a2);
      send_item(OP_FREE, 0, a1);
      send_item(OP_ALLOC, 40, 0);
      send_item(OP_ALLOC, 40, 0);
      free_live(live.size() - 2);
      send_item(OP_ALLOC, 33, 0);
      send_item(OP_ALLOC, 4000, 0);
      drain();

      // small growth steps, long hold-off so the block backs up its input
      write_reg(CSR_MIN_GROW, 1);
      write_reg(CSR_HEAP_LIMIT, 4095);
      hold_request = 400;
      repeat (20) send_item(OP_ALLOC, 16'($urandom_range(64)), 0, 1);
      random_items(330, 300);
      drain();

      // growth never possible: only the free list serves
      write_reg(CSR_MIN_GROW, 4095);
      random_items(250, 200);
      drain();

      // zero growth register, tight limit
      write_reg(CSR_MIN_GROW, 0);
      write_reg(CSR_HEAP_LIMIT, 1200);
      random_items(300, 400);
      drain();

      // limit at its floor: heap frozen
      write_reg(CSR_HEAP_LIMIT, 1);
      random_items(150, 200);
      drain();

      // drop everything, then a typical setting
      while (live.size() > 0) free_live($urandom_range(live.size() - 1));
      drain();
      write_reg(CSR_MIN_GROW, 64);
      write_reg(CSR_HEAP_LIMIT, 4095);
      random_items(650, 256);
      drain();

      if (sb.owed.size() != 0) report_mismatch($sformatf("%0d results never came", sb.owed.size()));
      $display("covered %0d good allocs, %0d failed allocs, %0d frees", n_alloc_ok, n_alloc_fail, n_free);
      $display("register settings swept incl. growth 0/1/4095 and limit 1/1200/4095");
      if (errors == 0) begin
         $display("next_fit_free_list_allocator_unit regression: pass");
      end else begin
         $display("next_fit_free_list_allocator_unit regression: fail");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+design
design/nffl_pkg.sv
design/nffl_hdr_ram.sv
design/nffl_ctrl.sv
design/next_fit_free_list_allocator_unit.sv
dv/next_fit_free_list_allocator_unit_tb.sv
